@@ rtl/btn_pkg.sv @@
package btn_pkg;

    localparam int ENTRIES_DEF    = 4;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INSERT = 3'd0;
    localparam op_t OP_SPLIT  = 3'd1;
    localparam op_t OP_FIND   = 3'd2;
    localparam op_t OP_POS    = 3'd3;
    localparam op_t OP_CLEAR  = 3'd4;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_MISS    = 2'd1;
    localparam status_t ST_REFUSED = 2'd2;

endpackage

@@ rtl/btn_if.sv @@
interface btn_req_if #(
    parameter int KEY_BITS   = btn_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = btn_pkg::VALUE_BITS_DEF
);
    import btn_pkg::*;

    logic                  valid;
    logic                  ready;
    op_t                   op;
    logic [KEY_BITS-1:0]   key_in;
    logic [VALUE_BITS-1:0] value_in;

    modport source (output valid, output op, output key_in, output value_in, input ready);
    modport sink   (input valid, input op, input key_in, input value_in, output ready);
endinterface

interface btn_rsp_if #(
    parameter int ENTRIES    = btn_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = btn_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = btn_pkg::VALUE_BITS_DEF
);
    import btn_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                  valid;
    logic                  ready;
    status_t               status;
    logic [CNT_W-1:0]      count_or_index;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic                  is_median;
    logic                  last;

    modport source (output valid, output status, output count_or_index, output key_out,
                    output value_out, output is_median, output last, input ready);
    modport sink   (input valid, input status, input count_or_index, input key_out,
                    input value_out, input is_median, input last, output ready);
endinterface

@@ rtl/btn_store.sv @@
module btn_store #(
    parameter int ENTRIES    = btn_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = btn_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = btn_pkg::VALUE_BITS_DEF,
    parameter int IDX_W      = $clog2(ENTRIES)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_value,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [VALUE_BITS-1:0] rd_value
);
    import btn_pkg::*;

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_idx]   <= wr_key;
            value_mem[wr_idx] <= wr_value;
        end
    end

    assign rd_key   = key_mem[rd_idx];
    assign rd_value = value_mem[rd_idx];

endmodule

@@ rtl/btree_node_sorted_store_top.sv @@
// channel | dir | fields                                        | handshake
// req     | in  | op, key_in, value_in                          | valid/ready
// rsp     | out | status, count_or_index, key_out, value_out,   | valid/ready
//         |     | is_median, last                               |
// One shared key comparator scans the node one entry per cycle; one store write
// port moves one entry per cycle. Insert: scan, shift, then the result; find and
// position: scan, then the result; split: scan, ENTRIES-ENTRIES/2+1 results, then
// up to ENTRIES/2 moves. rst_n clears the node count and the sequencer.
// A request is taken while an earlier result still waits in the output register.
module btree_node_sorted_store_top #(
    parameter int ENTRIES    = btn_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = btn_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = btn_pkg::VALUE_BITS_DEF
) (
    input logic    clk,
    input logic    rst_n,
    btn_req_if.sink   req,
    btn_rsp_if.source rsp
);
    import btn_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [CNT_W-1:0] ENT_C = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] MID_C = CNT_W'(ENTRIES / 2);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_EMIT, S_RESP} state_t;

    state_t                state_reg,  state_next;
    op_t                   op_reg,     op_next;
    logic [KEY_BITS-1:0]   key_reg,    key_next;
    logic [VALUE_BITS-1:0] val_reg,    val_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic [CNT_W-1:0]      idx_reg,    idx_next;
    logic [CNT_W-1:0]      pos_reg,    pos_next;
    logic [IDX_W-1:0]      shf_reg,    shf_next;
    status_t               st_reg,     st_next;
    logic [CNT_W-1:0]      ci_reg,     ci_next;
    logic [VALUE_BITS-1:0] fv_reg,     fv_next;
    logic                  ov_reg,     ov_next;
    status_t               ostat_reg,  ostat_next;
    logic [CNT_W-1:0]      oci_reg,    oci_next;
    logic [KEY_BITS-1:0]   okey_reg,   okey_next;
    logic [VALUE_BITS-1:0] oval_reg,   oval_next;
    logic                  omed_reg,   omed_next;
    logic                  olast_reg,  olast_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_value;
    logic [IDX_W-1:0]      rd_idx;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    logic slot_free;
    logic key_gt;
    logic key_eq;
    logic scan_end;

    btn_store #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_idx   (rd_idx),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign slot_free = !ov_reg || rsp.ready;
    assign key_gt    = rd_key > key_reg;
    assign key_eq    = rd_key == key_reg;
    assign scan_end  = idx_reg == count_reg;

    assign req.ready          = state_reg == S_IDLE;
    assign rsp.valid          = ov_reg;
    assign rsp.status         = ostat_reg;
    assign rsp.count_or_index = oci_reg;
    assign rsp.key_out        = okey_reg;
    assign rsp.value_out      = oval_reg;
    assign rsp.is_median      = omed_reg;
    assign rsp.last           = olast_reg;

    always_comb
    begin
        case (state_reg)
            S_SHIFT: rd_idx = shf_reg - IDX_W'(1);
            S_EMIT:  rd_idx = (idx_reg > pos_reg) ? IDX_W'(idx_reg - CNT_W'(1))
                                                  : IDX_W'(idx_reg);
            default: rd_idx = IDX_W'(idx_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        shf_next   = shf_reg;
        st_next    = st_reg;
        ci_next    = ci_reg;
        fv_next    = fv_reg;
        ov_next    = ov_reg && !rsp.ready;
        ostat_next = ostat_reg;
        oci_next   = oci_reg;
        okey_next  = okey_reg;
        oval_next  = oval_reg;
        omed_next  = omed_reg;
        olast_next = olast_reg;
        wr_en      = 1'b0;
        wr_idx     = shf_reg;
        wr_key     = rd_key;
        wr_value   = rd_value;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.op;
                    key_next = req.key_in;
                    val_next = req.value_in;
                    idx_next = '0;
                    st_next  = ST_OK;
                    ci_next  = count_reg;
                    fv_next  = '0;
                    case (req.op)
                        OP_INSERT:
                        begin
                            if (count_reg == ENT_C)
                            begin
                                st_next    = ST_MISS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_SPLIT:
                        begin
                            if (count_reg != ENT_C)
                            begin
                                st_next    = ST_REFUSED;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIND, OP_POS:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ci_next    = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (op_reg == OP_FIND)
                begin
                    if (scan_end)
                    begin
                        st_next    = ST_MISS;
                        state_next = S_RESP;
                    end
                    else if (key_eq)
                    begin
                        fv_next    = rd_value;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
                else if (scan_end || key_gt)
                begin
                    pos_next = idx_reg;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            shf_next   = IDX_W'(count_reg);
                            state_next = S_SHIFT;
                        end
                        OP_SPLIT:
                        begin
                            idx_next   = MID_C;
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            ci_next    = idx_reg;
                            state_next = S_RESP;
                        end
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (CNT_W'(shf_reg) > pos_reg)
                begin
                    shf_next = shf_reg - IDX_W'(1);
                end
                else
                begin
                    wr_idx   = IDX_W'(pos_reg);
                    wr_key   = key_reg;
                    wr_value = val_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        ci_next    = count_reg + CNT_W'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        count_next = MID_C;
                        state_next = S_IDLE;
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = ST_OK;
                    oci_next   = MID_C;
                    okey_next  = (idx_reg == pos_reg) ? key_reg : rd_key;
                    oval_next  = (idx_reg == pos_reg) ? val_reg : rd_value;
                    omed_next  = idx_reg == MID_C;
                    olast_next = idx_reg == ENT_C;
                    if (idx_reg == ENT_C)
                    begin
                        if (pos_reg < MID_C)
                        begin
                            shf_next   = IDX_W'(MID_C - CNT_W'(1));
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = MID_C;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = st_reg;
                    oci_next   = ci_reg;
                    okey_next  = '0;
                    oval_next  = fv_reg;
                    omed_next  = 1'b0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_INSERT;
            key_reg   <= '0;
            val_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            shf_reg   <= '0;
            st_reg    <= ST_OK;
            ci_reg    <= '0;
            fv_reg    <= '0;
            ov_reg    <= 1'b0;
            ostat_reg <= ST_OK;
            oci_reg   <= '0;
            okey_reg  <= '0;
            oval_reg  <= '0;
            omed_reg  <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
            val_reg   <= val_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            shf_reg   <= shf_next;
            st_reg    <= st_next;
            ci_reg    <= ci_next;
            fv_reg    <= fv_next;
            ov_reg    <= ov_next;
            ostat_reg <= ostat_next;
            oci_reg   <= oci_next;
            okey_reg  <= okey_next;
            oval_reg  <= oval_next;
            omed_reg  <= omed_next;
            olast_reg <= olast_next;
        end
    end

endmodule
